FILE: rtl/dfa_lpm_pkg.sv
// ----------------------------------------------------------------------------
// dfa_lpm_pkg
// Shared types and codes of the automaton prefix matcher: operation codes and
// the packed words that travel on the input and output channels.
// ----------------------------------------------------------------------------
package dfa_lpm_pkg;

  // Operation carried by an input word.
  typedef enum logic [1:0] {
    OP_WR_TRANS = 2'd0,
    OP_WR_FINAL = 2'd1,
    OP_BYTE     = 2'd2,
    OP_EOS      = 2'd3
  } op_e;

  localparam int unsigned OutLenWidth = 16;
  localparam logic [31:0] OutLenMax   = 32'h0000_FFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] state_sel;
    logic [7:0] symbol;
    logic [3:0] next_state;
    logic       entry_valid;
    logic       final_flag;
  } in_word_t;

  typedef struct packed {
    logic                   accepted;
    logic                   stopped_on_byte;
    logic [OutLenWidth-1:0] prefix_len;
  } out_word_t;

endpackage

FILE: rtl/dfa_longest_prefix_matcher.sv
// ----------------------------------------------------------------------------
// dfa_longest_prefix_matcher
// Table-driven automaton that reports the longest prefix ending in a final
// state for each string of bytes.
// ----------------------------------------------------------------------------
// After reset the block sweeps the transition table to invalid, one entry per
// cycle; during that time in_ready_o stays low. From then on it takes one
// input word per cycle, every kind of word included. A data byte looks up
// {state, byte} in a single-port table memory with a registered read; the
// next state coming out of that memory is fed straight back to the address of
// the following byte's lookup, so this memory port and its feedback path set
// the rate of one byte per clock. Results leave through an output register.
// The input is held off only when a second result is ready while the first
// one still waits in that register and is not taken in the same cycle. Writes
// of transitions and final marks act at once, also in the middle of a string.
// ----------------------------------------------------------------------------
module dfa_longest_prefix_matcher
  import dfa_lpm_pkg::*;
#(
  parameter int unsigned NUM_STATES = 16,
  parameter int unsigned LEN_WIDTH  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  // State index width and table geometry: one row of 256 entries per state.
  localparam int unsigned StateW    = $clog2(NUM_STATES);
  localparam int unsigned EntryW    = StateW + 1;
  localparam int unsigned TblDepth  = NUM_STATES * 256;
  localparam int unsigned TblAddrW  = StateW + 8;

  // Clearing sweep.
  logic                clr_busy;
  logic [TblAddrW-1:0] clr_addr;

  // Table memory port.
  logic                ram_en, ram_we;
  logic [TblAddrW-1:0] ram_addr;
  logic [EntryW-1:0]   ram_wdata, ram_rdata;

  // Lookup stage.
  logic                in_accept;
  logic                in_is_trans, in_is_byte;
  logic                trans_ok;
  logic                s1_valid_q;
  in_word_t            s1_item_q;
  logic                s1_emit, s1_stall, s1_fire;
  logic [StateW-1:0]   cur_fwd;
  out_word_t           s1_result;

  // Output register.
  logic                out_valid_q, out_valid_d;
  out_word_t           out_data_q, out_data_d;
  logic                out_free;

  dfa_lpm_clear #(
    .Depth (TblDepth)
  ) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  // A result can move into the output register when it is empty or drains
  // this cycle. Otherwise a word that wants to report stalls in place.
  assign out_free  = !out_valid_q || out_ready_i;
  assign s1_stall  = s1_emit && !out_free;
  assign s1_fire   = s1_valid_q && !s1_stall;

  assign in_ready_o = !clr_busy && !s1_stall;
  assign in_accept  = in_valid_i && in_ready_o;

  assign in_is_trans = (in_data_i.opcode == OP_WR_TRANS);
  assign in_is_byte  = (in_data_i.opcode == OP_BYTE);
  assign trans_ok    = (32'(in_data_i.state_sel) < NUM_STATES) &&
                       (32'(in_data_i.next_state) < NUM_STATES);

  // The byte lookup uses the state the previous word leaves behind, taken
  // from the second stage before it is registered.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {cur_fwd, in_data_i.symbol};
    ram_wdata = '0;
    if (clr_busy) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      ram_addr = clr_addr;
    end else if (in_accept && in_is_trans) begin
      ram_en   = trans_ok;
      ram_we   = 1'b1;
      ram_addr = {StateW'(in_data_i.state_sel), in_data_i.symbol};
      if (in_data_i.entry_valid) begin
        ram_wdata = {1'b1, StateW'(in_data_i.next_state)};
      end
    end else if (in_accept && in_is_byte) begin
      ram_en = 1'b1;
    end
  end

  dfa_lpm_ram #(
    .Width (EntryW),
    .Depth (TblDepth)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Second stage holds the accepted word while its table entry is read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
  end

  dfa_lpm_step #(
    .NumStates (NUM_STATES),
    .LenWidth  (LEN_WIDTH),
    .StateW    (StateW)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid_q),
    .fire_i        (s1_fire),
    .item_i        (s1_item_q),
    .entry_valid_i (ram_rdata[EntryW-1]),
    .entry_state_i (ram_rdata[StateW-1:0]),
    .cur_fwd_o     (cur_fwd),
    .emit_o        (s1_emit),
    .result_o      (s1_result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s1_fire && s1_emit) begin
      out_valid_d = 1'b1;
      out_data_d  = s1_result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // No word may enter while the table is still being swept.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o)
    else $error("input accepted during table clearing");

  // A stall only ever comes from a full output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_stall |-> (out_valid_q && !out_ready_i))
    else $error("second stage stalled without a blocked result");

  // Every accepted word reaches the second stage on the next cycle.
  a_accept_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted word lost before the lookup stage");

endmodule

FILE: rtl/dfa_lpm_ram.sv
// ----------------------------------------------------------------------------
// dfa_lpm_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module dfa_lpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dfa_lpm_clear.sv
// ----------------------------------------------------------------------------
// dfa_lpm_clear
// Post-reset sweep that writes every transition entry to invalid, one entry
// per cycle.
// ----------------------------------------------------------------------------
module dfa_lpm_clear #(
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     busy_o,
  output logic [$clog2(Depth)-1:0] addr_o
);

  localparam int unsigned AddrWidth = $clog2(Depth);
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(Depth - 1);

  typedef enum logic [1:0] {
    CLR_SWEEP = 2'b01,
    CLR_DONE  = 2'b10
  } clr_state_e;

  clr_state_e           state_q, state_d;
  logic [AddrWidth-1:0] addr_q, addr_d;

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      CLR_SWEEP: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == LastAddr) begin
          state_d = CLR_DONE;
        end
      end
      CLR_DONE: begin
        addr_d = addr_q;
      end
      default: begin
        state_d = CLR_SWEEP;
        addr_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLR_SWEEP;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  assign busy_o = (state_q == CLR_SWEEP);
  assign addr_o = addr_q;

endmodule

FILE: rtl/dfa_lpm_step.sv
// ----------------------------------------------------------------------------
// dfa_lpm_step
// Second stage of the matcher: holds the automaton state, run and best
// lengths, the halt flag and the final marks, and forms the result word.
// ----------------------------------------------------------------------------
module dfa_lpm_step
  import dfa_lpm_pkg::*;
#(
  parameter int unsigned NumStates = 16,
  parameter int unsigned LenWidth  = 16,
  parameter int unsigned StateW    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              fire_i,
  input  in_word_t          item_i,
  input  logic              entry_valid_i,
  input  logic [StateW-1:0] entry_state_i,
  output logic [StateW-1:0] cur_fwd_o,
  output logic              emit_o,
  output out_word_t         result_o
);

  logic [StateW-1:0]    cur_state_q, cur_state_d;
  logic [LenWidth-1:0]  run_q, run_d;
  logic [LenWidth-1:0]  best_q, best_d;
  logic                 halted_q, halted_d;
  logic [NumStates-1:0] final_q, final_d;

  logic                 is_byte, is_eos, is_final_wr;
  logic                 take_edge;
  logic [StateW-1:0]    fin_idx;
  logic [StateW-1:0]    sel_idx;
  logic                 sel_ok;
  logic [LenWidth-1:0]  run_inc;
  logic [31:0]          best_ext;

  assign is_byte     = (item_i.opcode == OP_BYTE);
  assign is_eos      = (item_i.opcode == OP_EOS);
  assign is_final_wr = (item_i.opcode == OP_WR_FINAL);
  assign take_edge   = is_byte && !halted_q && entry_valid_i;

  // One read of the final marks: the target state on a taken edge, otherwise
  // the state the string stopped in.
  assign fin_idx = take_edge ? entry_state_i : cur_state_q;
  assign sel_idx = StateW'(item_i.state_sel);
  assign sel_ok  = (32'(item_i.state_sel) < NumStates);
  assign run_inc = (run_q == '1) ? run_q : run_q + 1'b1;

  always_comb begin
    cur_state_d = cur_state_q;
    run_d       = run_q;
    best_d      = best_q;
    halted_d    = halted_q;
    final_d     = final_q;
    if (fire_i) begin
      if (is_final_wr && sel_ok) begin
        final_d[sel_idx] = item_i.final_flag;
      end
      if (is_byte && !halted_q) begin
        if (entry_valid_i) begin
          cur_state_d = entry_state_i;
          run_d       = run_inc;
          if (final_q[fin_idx]) begin
            best_d = run_inc;
          end
        end else begin
          halted_d = 1'b1;
        end
      end
      if (is_eos) begin
        cur_state_d = '0;
        run_d       = '0;
        best_d      = '0;
        halted_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_state_q <= '0;
      run_q       <= '0;
      best_q      <= '0;
      halted_q    <= 1'b0;
      final_q     <= '0;
    end else begin
      cur_state_q <= cur_state_d;
      run_q       <= run_d;
      best_q      <= best_d;
      halted_q    <= halted_d;
      final_q     <= final_d;
    end
  end

  assign cur_fwd_o = cur_state_d;
  assign emit_o    = valid_i && !halted_q && (is_eos || (is_byte && !entry_valid_i));

  assign best_ext                 = 32'(best_q);
  assign result_o.accepted        = final_q[fin_idx];
  assign result_o.stopped_on_byte = is_byte;
  assign result_o.prefix_len      = (best_ext > OutLenMax) ? OutLenWidth'(OutLenMax)
                                                           : best_ext[OutLenWidth-1:0];

  // End of string always leaves the automaton running again.
  a_eos_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_eos) |=> (!halted_q && cur_state_q == '0))
    else $error("end of string did not restart the automaton");

  // Only checked, in-range targets are ever stored, so the state stays legal.
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_state_q) < NumStates)
    else $error("automaton state out of range");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// dfa_longest_prefix_matcher testbench
// Drives table writes, data bytes and end-of-string words into the matcher.
// A model inside the bench predicts each stop report, and every report is
// compared against it in order. Handshakes on both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import dfa_lpm_pkg::*;

  localparam int unsigned StateCount   = 16;
  localparam int unsigned RandomWords  = 1000;
  localparam int unsigned LongRun      = 48;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned Deadline     = 2_000_000;

  // One word waiting to be sent, with the idle cycles that come before it.
  typedef struct {
    in_word_t    word;
    int unsigned gap;
  } paced_word_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  dfa_longest_prefix_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Matcher model: transition table, final marks and the running match.
  bit [4:0]    hop_tab [StateCount][256];
  bit          accept_mark [StateCount];
  bit [3:0]    cur_state;
  bit [15:0]   run_count;
  bit [15:0]   best_prefix;
  bit          stuck;
  out_word_t   due_reports[$];

  // Shadow of the table as the stimulus will leave it, used to steer strings.
  bit          plan_ok [StateCount][256];
  bit [3:0]    plan_next [StateCount][256];
  bit [3:0]    plan_state;
  bit          plan_stuck;
  int unsigned live_words;
  bit          flow_calm;

  paced_word_t feed_words[$];
  int unsigned idle_cycles;
  int unsigned drain_hold;
  bit          drain_calm;
  bit          in_took;
  bit          out_took;
  int unsigned errors;

  // Applies one accepted word to the model. Returns 1 with the report when
  // the word stops a string. The report is built from the state before the
  // word acts, which is what both a stopping byte and an end of string show.
  function automatic bit predict_report(input in_word_t w, output out_word_t r);
    bit [4:0] hop;
    bit       fire;
    fire              = 1'b0;
    r.accepted        = accept_mark[cur_state];
    r.stopped_on_byte = (op_e'(w.opcode) == OP_BYTE);
    r.prefix_len      = best_prefix;
    case (op_e'(w.opcode))
      OP_WR_TRANS: begin
        if (w.state_sel < StateCount && w.next_state < StateCount)
          hop_tab[w.state_sel][w.symbol] = w.entry_valid ? {1'b1, w.next_state} : 5'd0;
      end
      OP_WR_FINAL: begin
        if (w.state_sel < StateCount)
          accept_mark[w.state_sel] = w.final_flag;
      end
      OP_BYTE: begin
        if (!stuck) begin
          hop = hop_tab[cur_state][w.symbol];
          if (!hop[4]) begin
            stuck = 1'b1;
            fire  = 1'b1;
          end else begin
            cur_state = hop[3:0];
            if (run_count != 16'hFFFF)
              run_count++;
            if (accept_mark[cur_state])
              best_prefix = run_count;
          end
        end
      end
      default: begin
        fire        = !stuck;
        cur_state   = '0;
        run_count   = '0;
        best_prefix = '0;
        stuck       = 1'b0;
      end
    endcase
    return fire;
  endfunction

  // Long stretches without gaps alternate with stretches of random gaps.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 39) == 0)
      flow_calm = !flow_calm;
    return flow_calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic in_word_t rand_word(input op_e op);
    in_word_t w;
    w        = in_word_t'(20'($urandom));
    w.opcode = op;
    return w;
  endfunction

  // Queues a word and follows it in the shadow table. Bytes and ends of
  // string that the matcher will ignore are not counted as live words.
  function automatic void enqueue(input in_word_t w, input int unsigned gap);
    paced_word_t pw;
    pw.word = w;
    pw.gap  = gap;
    feed_words = {feed_words, pw};
    case (op_e'(w.opcode))
      OP_WR_TRANS: begin
        plan_ok[w.state_sel][w.symbol]   = w.entry_valid;
        plan_next[w.state_sel][w.symbol] = w.next_state;
        live_words++;
      end
      OP_WR_FINAL: live_words++;
      OP_BYTE: begin
        if (!plan_stuck) begin
          live_words++;
          if (plan_ok[plan_state][w.symbol])
            plan_state = plan_next[plan_state][w.symbol];
          else
            plan_stuck = 1'b1;
        end
      end
      default: begin
        if (!plan_stuck)
          live_words++;
        plan_state = '0;
        plan_stuck = 1'b0;
      end
    endcase
  endfunction

  function automatic void put_trans(input bit [3:0] sel, input bit [7:0] sym,
                                    input bit [3:0] nxt, input bit ev);
    in_word_t w;
    w             = rand_word(OP_WR_TRANS);
    w.state_sel   = sel;
    w.symbol      = sym;
    w.next_state  = nxt;
    w.entry_valid = ev;
    enqueue(w, pick_gap());
  endfunction

  function automatic void put_final(input bit [3:0] sel, input bit ff);
    in_word_t w;
    w            = rand_word(OP_WR_FINAL);
    w.state_sel  = sel;
    w.final_flag = ff;
    enqueue(w, pick_gap());
  endfunction

  function automatic void put_byte(input bit [7:0] sym, input int unsigned gap);
    in_word_t w;
    w        = rand_word(OP_BYTE);
    w.symbol = sym;
    enqueue(w, gap);
  endfunction

  function automatic void put_eos(input int unsigned gap);
    enqueue(rand_word(OP_EOS), gap);
  endfunction

  // Sender: a word goes out once its gap of idle cycles has passed since the
  // previous word was taken. A zero gap keeps valid high back to back.
  always @(negedge clk_i) begin : feed
    paced_word_t slot;
    logic        next_valid;
    next_valid = in_valid;
    if (rst_ni) begin
      if (in_valid && in_took)
        next_valid = 1'b0;
      if (!next_valid && feed_words.size() != 0) begin
        if (idle_cycles < feed_words[0].gap) begin
          idle_cycles++;
        end else begin
          slot        = feed_words.pop_front();
          in_data    <= slot.word;
          next_valid  = 1'b1;
          idle_cycles = 0;
        end
      end
    end
    in_valid <= next_valid;
  end

  // Receiver: after each report it holds ready low for a drawn number of
  // cycles, and now and then drops it on its own for a drawn number of cycles.
  always @(negedge clk_i) begin : drain
    if (out_took) begin
      if ($urandom_range(0, 29) == 0)
        drain_calm = !drain_calm;
      drain_hold = drain_calm ? 0 : $urandom_range(0, 6);
    end else if (drain_hold == 0 && !drain_calm && $urandom_range(0, 15) == 0) begin
      drain_hold = $urandom_range(1, 6);
    end
    if (drain_hold != 0) begin
      drain_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Both handshakes are observed at the rising edge. Reports are checked
  // before the word taken in the same cycle is predicted.
  always @(posedge clk_i) begin : watch
    out_word_t want;
    out_word_t got;
    in_took  = rst_ni && in_valid && (in_ready === 1'b1);
    out_took = rst_ni && (out_valid === 1'b1) && out_ready;
    if (out_took) begin
      got = out_data;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report accepted=%0b stopped_on_byte=%0b prefix_len=%0d",
                 $time, got.accepted, got.stopped_on_byte, got.prefix_len);
        errors++;
      end else begin
        want = due_reports.pop_front();
        if (got.accepted !== want.accepted ||
            got.stopped_on_byte !== want.stopped_on_byte ||
            got.prefix_len !== want.prefix_len) begin
          $display("%0t: report mismatch, expected accepted=%0b stopped_on_byte=%0b %s%0d",
                   $time, want.accepted, want.stopped_on_byte, "prefix_len=",
                   want.prefix_len);
          $display("%0t:   actual accepted=%0b stopped_on_byte=%0b prefix_len=%0d",
                   $time, got.accepted, got.stopped_on_byte, got.prefix_len);
          errors++;
        end
      end
    end
    if (in_took && predict_report(in_data, want))
      due_reports = {due_reports, want};
  end

  initial begin : scenario
    in_word_t    w;
    bit [7:0]    alpha [4];
    bit [7:0]    sym;
    bit          found;
    int unsigned steps;
    int unsigned roll;
    int unsigned k0;

    // Empty strings with and without a final start state, then a stop on
    // the very first byte, with the bytes and end after it ignored.
    put_eos(pick_gap());
    put_final(4'd0, 1'b1);
    put_eos(pick_gap());
    put_byte(8'hFF, pick_gap());
    put_byte(8'h00, pick_gap());
    put_eos(pick_gap());
    // A two-state loop between the lowest and highest state on the lowest
    // and highest byte.
    put_trans(4'd0, 8'h00, 4'd15, 1'b1);
    put_trans(4'd15, 8'hFF, 4'd0, 1'b1);
    put_final(4'd15, 1'b1);
    put_final(4'd0, 1'b0);
    put_byte(8'h00, pick_gap());
    put_byte(8'hFF, pick_gap());
    put_byte(8'h00, pick_gap());
    put_eos(pick_gap());
    // Removing a transition in the middle of a string takes effect at once.
    put_byte(8'h00, pick_gap());
    put_trans(4'd15, 8'hFF, 4'd0, 1'b0);
    put_byte(8'hFF, pick_gap());
    put_eos(pick_gap());
    put_trans(4'd0, 8'h00, 4'd15, 1'b0);
    put_byte(8'h00, pick_gap());
    put_eos(pick_gap());
    // Back-to-back reports push on the output register.
    put_eos(0);
    put_eos(0);
    put_final(4'd15, 1'b0);

    // Random part: each round draws a small alphabet, fills most of the
    // table on it, then runs strings that mostly follow live transitions.
    live_words = 0;
    while (live_words < RandomWords) begin
      for (int k = 0; k < 4; k++)
        alpha[k] = 8'($urandom);
      for (int s = 0; s < StateCount; s++) begin
        for (int k = 0; k < 4; k++)
          put_trans(4'(s), alpha[k], 4'($urandom), $urandom_range(0, 9) < 8);
        put_final(4'(s), $urandom_range(0, 9) < 4);
      end
      for (int n = 0; n < 25; n++) begin
        steps = $urandom_range(0, 12);
        for (int j = 0; j < steps; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            w = rand_word(op_e'($urandom_range(0, 1)));
            enqueue(w, pick_gap());
          end else begin
            sym = 8'($urandom);
            if (roll < 90) begin
              k0    = $urandom_range(0, 3);
              found = 1'b0;
              for (int k = 0; k < 4; k++) begin
                if (!found && plan_ok[plan_state][alpha[(k0 + k) % 4]]) begin
                  sym   = alpha[(k0 + k) % 4];
                  found = 1'b1;
                end
              end
            end
            put_byte(sym, pick_gap());
          end
        end
        put_eos(pick_gap());
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) put_eos(0);
      end
    end

    // One long string on a self loop of a final state, stopped by a byte
    // with no transition, then an empty string after it.
    put_final(4'd0, 1'b1);
    put_trans(4'd0, 8'h5A, 4'd0, 1'b1);
    put_trans(4'd0, 8'h00, 4'd0, 1'b0);
    repeat (LongRun)
      put_byte(8'h5A, ($urandom_range(0, 127) == 0) ? $urandom_range(1, 6) : 0);
    put_byte(8'h00, 0);
    put_eos(0);
    put_eos(0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (feed_words.size() != 0 || in_valid) @(posedge clk_i);
    while (due_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (errors == 0)
      $display("dfa_longest_prefix_matcher regression: pass");
    else
      $display("dfa_longest_prefix_matcher regression: fail");
    $finish;
  end

  initial begin : watchdog
    #Deadline;
    $display("dfa_longest_prefix_matcher regression: fail");
    $finish;
  end

endmodule
